[hw/rtl/chdc_pkg.sv]
// ----------------------------------------------------------------------------
// chdc_pkg
// Shared types, opcodes, limits and the month-length table for the calendar
// hour/date counter.
// ----------------------------------------------------------------------------
package chdc_pkg;

    // Opcodes carried by each request.
    localparam logic [2:0] OP_LOAD      = 3'd0;
    localparam logic [2:0] OP_HOUR_UP   = 3'd1;
    localparam logic [2:0] OP_HOUR_DOWN = 3'd2;
    localparam logic [2:0] OP_DAY_UP    = 3'd3;
    localparam logic [2:0] OP_DAY_DOWN  = 3'd4;

    // Calendar limits.
    localparam logic [13:0] LAST_YEAR  = 14'd9999;
    localparam logic [13:0] FIRST_YEAR = 14'd0;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  FIRST_DAY  = 5'd1;
    localparam logic [4:0]  LAST_HOUR  = 5'd23;
    localparam logic [4:0]  FIRST_HOUR = 5'd0;

    // State after reset: midnight, 1 January 2000.
    localparam logic [13:0] RESET_YEAR  = 14'd2000;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;
    localparam logic [4:0]  RESET_HOUR  = 5'd0;

    // Divisibility by 25 through the multiplicative inverse of 25 modulo 2^16:
    // y is a multiple of 25 exactly when (y * INV25) mod 2^16 <= DIV25_LIMIT.
    localparam logic [15:0] INV25       = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    // Days per month in a common year, January first.
    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Calendar state as it moves between the counter and the step logic.
    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
    } t_cal_state;

    // Length of a month; zero for a month number outside 1 to 12.
    function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                 input logic       leap);
        logic [4:0] len;
        len = 5'd0;
        if ((month >= MONTH_JAN) && (month <= MONTH_DEC)) begin
            len = MONTH_LEN[month - MONTH_JAN];
            if ((month == 4'd2) && leap) begin
                len = 5'd29;
            end
        end
        return len;
    endfunction

endpackage

[hw/rtl/chdc_leap.sv]
// ----------------------------------------------------------------------------
// chdc_leap
// Gregorian leap-year test on a 14-bit year, using masks for the powers of
// two and a constant-inverse multiply for the factor of 25.
// ----------------------------------------------------------------------------
module chdc_leap (
    input  logic [13:0] i_year,
    output logic        o_leap
);
    import chdc_pkg::*;

    logic [15:0] w_prod;
    logic        w_div4;
    logic        w_div16;
    logic        w_div25;

    // Product modulo 2^16 falls at or below the limit only for multiples of 25.
    assign w_prod  = {2'd0, i_year} * INV25;
    assign w_div25 = (w_prod <= DIV25_LIMIT);

    assign w_div4  = (i_year[1:0] == 2'b00);
    assign w_div16 = (i_year[3:0] == 4'b0000);

    // Divisible by 400 means by 16 and 25; a century year otherwise is common.
    assign o_leap = w_div4 && (!w_div25 || w_div16);

endmodule

[hw/rtl/chdc_step.sv]
// ----------------------------------------------------------------------------
// chdc_step
// Single-pass next-state logic: applies one opcode to the current calendar
// state and flags requests that are refused.
// ----------------------------------------------------------------------------
module chdc_step (
    input  chdc_pkg::t_cal_state i_cur,
    input  logic [2:0]           i_opcode,
    input  logic [4:0]           i_load_day,
    input  logic [3:0]           i_load_month,
    input  logic [13:0]          i_load_year,
    input  logic [4:0]           i_load_hour,
    output chdc_pkg::t_cal_state o_next,
    output logic                 o_rejected
);
    import chdc_pkg::*;

    logic [13:0] w_leap_year;
    logic        w_leap;
    logic [4:0]  w_cur_len;
    logic [4:0]  w_prev_len;
    logic [4:0]  w_load_len;
    logic        w_load_ok;
    t_cal_state  w_up;
    logic        w_up_ok;
    t_cal_state  w_down;
    logic        w_down_ok;

    // A load needs the leap flag of the loaded year, every step that of the
    // current one, so a single test is shared.
    assign w_leap_year = (i_opcode == OP_LOAD) ? i_load_year : i_cur.year;

    chdc_leap u_leap (
        .i_year (w_leap_year),
        .o_leap (w_leap)
    );

    assign w_cur_len  = days_in_month(i_cur.month, w_leap);
    assign w_prev_len = days_in_month(i_cur.month - 4'd1, w_leap);
    assign w_load_len = days_in_month(i_load_month, w_leap);

    // A load must name a real hour and a real date within the year range.
    assign w_load_ok = (i_load_month >= MONTH_JAN) && (i_load_month <= MONTH_DEC) &&
                       (i_load_year <= LAST_YEAR) && (i_load_hour <= LAST_HOUR) &&
                       (i_load_day >= FIRST_DAY) && (i_load_day <= w_load_len);

    // One day forward, refused past the end of the last year.
    always_comb begin
        w_up    = i_cur;
        w_up_ok = 1'b1;
        if (i_cur.day >= w_cur_len) begin
            if (i_cur.month >= MONTH_DEC) begin
                if (i_cur.year >= LAST_YEAR) begin
                    w_up_ok = 1'b0;
                end else begin
                    w_up.year  = i_cur.year + 14'd1;
                    w_up.month = MONTH_JAN;
                end
            end else begin
                w_up.month = i_cur.month + 4'd1;
            end
            if (w_up_ok) begin
                w_up.day = FIRST_DAY;
            end
        end else begin
            w_up.day = i_cur.day + 5'd1;
        end
    end

    // One day back, refused before the start of the first year.
    always_comb begin
        w_down    = i_cur;
        w_down_ok = 1'b1;
        if (i_cur.day <= FIRST_DAY) begin
            if (i_cur.month <= MONTH_JAN) begin
                if (i_cur.year == FIRST_YEAR) begin
                    w_down_ok = 1'b0;
                end else begin
                    w_down.year  = i_cur.year - 14'd1;
                    w_down.month = MONTH_DEC;
                    w_down.day   = days_in_month(MONTH_DEC, 1'b0);
                end
            end else begin
                w_down.month = i_cur.month - 4'd1;
                w_down.day   = w_prev_len;
            end
        end else begin
            w_down.day = i_cur.day - 5'd1;
        end
    end

    // Opcode selection; hour steps carry into day steps at midnight.
    always_comb begin
        o_next     = i_cur;
        o_rejected = 1'b0;
        unique case (i_opcode)
            OP_LOAD: begin
                if (w_load_ok) begin
                    o_next.year  = i_load_year;
                    o_next.month = i_load_month;
                    o_next.day   = i_load_day;
                    o_next.hour  = i_load_hour;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            OP_HOUR_UP: begin
                if (i_cur.hour >= LAST_HOUR) begin
                    if (w_up_ok) begin
                        o_next      = w_up;
                        o_next.hour = FIRST_HOUR;
                    end else begin
                        o_rejected = 1'b1;
                    end
                end else begin
                    o_next.hour = i_cur.hour + 5'd1;
                end
            end
            OP_HOUR_DOWN: begin
                if (i_cur.hour == FIRST_HOUR) begin
                    if (w_down_ok) begin
                        o_next      = w_down;
                        o_next.hour = LAST_HOUR;
                    end else begin
                        o_rejected = 1'b1;
                    end
                end else begin
                    o_next.hour = i_cur.hour - 5'd1;
                end
            end
            OP_DAY_UP: begin
                if (w_up_ok) begin
                    o_next = w_up;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            OP_DAY_DOWN: begin
                if (w_down_ok) begin
                    o_next = w_down;
                end else begin
                    o_rejected = 1'b1;
                end
            end
            default: begin
                o_next     = i_cur;
                o_rejected = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/calendar_hour_date_counter_core.sv]
// ----------------------------------------------------------------------------
// calendar_hour_date_counter_core
// Up/down Gregorian calendar counter with hour resolution. It accepts one
// request per clock while no stall holds it and returns one result per
// request: the hour, day, month and year after the request, with a reject
// flag for refused loads and for steps past 31 December 9999 or before
// 1 January 0. Requests are registered on entry in the input register; the
// next state is worked out combinationally from that register and the state
// registers and is registered into the result register, which presents it.
// The sustained rate is one request per cycle when the output is not
// stalled, held by the combinational step logic feeding the state registers.
// A result waiting on a stalled output does not stop a further request from
// entering the input register while that register is empty.
// ----------------------------------------------------------------------------
module calendar_hour_date_counter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [4:0]  i_load_day,
    input  logic [3:0]  i_load_month,
    input  logic [13:0] i_load_year,
    input  logic [4:0]  i_load_hour,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_day_now,
    output logic [3:0]  o_month_now,
    output logic [13:0] o_year_now,
    output logic [4:0]  o_hour_now,
    output logic        o_rejected
);
    import chdc_pkg::*;

    logic        r_in_valid;
    logic [2:0]  r_opcode;
    logic [4:0]  r_load_day;
    logic [3:0]  r_load_month;
    logic [13:0] r_load_year;
    logic [4:0]  r_load_hour;
    t_cal_state  r_state;
    logic        r_out_valid;
    t_cal_state  r_out_state;
    logic        r_out_rejected;
    t_cal_state  n_state;
    logic        n_rejected;
    logic        w_adv;
    logic        w_take;
    logic        w_fire;

    // Handshake: the result register frees when empty or being taken.
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_fire     = r_in_valid && w_adv;

    // Control state: valid flags and the calendar counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state.year  <= RESET_YEAR;
            r_state.month <= RESET_MONTH;
            r_state.day   <= RESET_DAY;
            r_state.hour  <= RESET_HOUR;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (w_adv) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_opcode     <= i_opcode;
            r_load_day   <= i_load_day;
            r_load_month <= i_load_month;
            r_load_year  <= i_load_year;
            r_load_hour  <= i_load_hour;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_state    <= n_state;
            r_out_rejected <= n_rejected;
        end
    end

    // Next-state logic for the request held in the input register.
    chdc_step u_step (
        .i_cur        (r_state),
        .i_opcode     (r_opcode),
        .i_load_day   (r_load_day),
        .i_load_month (r_load_month),
        .i_load_year  (r_load_year),
        .i_load_hour  (r_load_hour),
        .o_next       (n_state),
        .o_rejected   (n_rejected)
    );

    assign o_out_valid = r_out_valid;
    assign o_day_now   = r_out_state.day;
    assign o_month_now = r_out_state.month;
    assign o_year_now  = r_out_state.year;
    assign o_hour_now  = r_out_state.hour;
    assign o_rejected  = r_out_rejected;

    // A pending result always shows the counters as they now stand.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_out_state == r_state))
        else $error("pending result differs from the calendar state");

    // A refused request leaves the counters untouched.
    a_reject_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && n_rejected) |=> (r_state == $past(r_state)))
        else $error("refused request changed the calendar state");

    // The counters never leave the calendar range.
    a_state_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.month >= MONTH_JAN) && (r_state.month <= MONTH_DEC) &&
        (r_state.hour <= LAST_HOUR) && (r_state.day >= FIRST_DAY) &&
        (r_state.year <= LAST_YEAR))
        else $error("calendar state out of range");

    // The input side stalls only while a request is held and cannot move on.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked request");

endmodule
